/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ptrl_pkg.sv */
package ptrl_pkg;

	// record marks
	localparam logic [7:0] DATA_MARK = 8'h3C;
	localparam logic [7:0] EXEC_MARK = 8'h78;

	typedef struct packed {
		logic        write_valid;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic        record_end;
		logic        checksum_error;
		logic        exec_valid;
		logic [15:0] exec_address;
		logic        finished;
	} res_t;

endpackage

/* rtl/paper_tape_record_loader_top.sv */
// Paper tape record loader: one tape byte in, one result word out per byte.
// The result word for a byte is registered in the result register, or in the skid entry while the sink stalls.
// Throughput: one word per cycle while the skid entry is empty; the parse state advances in one step per byte.
// A two-entry output stage (result register plus skid) takes one more byte under a stalled sink, then stalls input.
// Reset (arst_n low, asynchronous): parser waits for the first leader byte, all counts,
// sums and addresses clear, and both output entries are emptied.
`include "assert_macros.svh"

module paper_tape_record_loader_top
	import ptrl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// tape byte channel
	input  logic        tape_valid,
	output logic        tape_stall,
	input  logic [7:0]  tape_byte,

	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        write_valid,
	output logic [15:0] write_address,
	output logic [7:0]  write_data,
	output logic        record_end,
	output logic        checksum_error,
	output logic        exec_valid,
	output logic [15:0] exec_address,
	output logic        finished
);

	// Parse phases. Codes past DONE cannot arise and behave as SCAN.
	typedef enum logic [3:0] {
		PH_FIRST  = 4'd0,
		PH_LEADER = 4'd1,
		PH_SKIP   = 4'd2,
		PH_SCAN   = 4'd3,
		PH_LEN    = 4'd4,
		PH_ALO    = 4'd5,
		PH_AHI    = 4'd6,
		PH_DATA   = 4'd7,
		PH_CSUM   = 4'd8,
		PH_XLO    = 4'd9,
		PH_XHI    = 4'd10,
		PH_DONE   = 4'd11
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  leader_q, leader_n;
	logic [7:0]  remain_q, remain_n;
	logic [15:0] addr_q, addr_n;
	logic [7:0]  sum_q, sum_n;
	logic [7:0]  xlo_q, xlo_n;
	logic [7:0]  remain_dec;

	res_t res_n;
	res_t res_q;      // word on the outputs
	res_t skid_q;     // word parked while the sink stalls
	logic res_valid_q;
	logic skid_valid_q;

	logic in_fire;
	logic out_fire;

	// Input is refused only while the skid entry holds a word; registered, so
	// stall never depends on the sink combinationally.
	assign tape_stall = skid_valid_q;
	assign in_fire    = tape_valid && !skid_valid_q;
	assign out_fire   = res_valid_q && !result_stall;

	assign remain_dec = remain_q - 8'd1;

	// Next parse state and the result word for the byte on the input.
	always_comb begin
		phase_n  = phase_q;
		leader_n = leader_q;
		remain_n = remain_q;
		addr_n   = addr_q;
		sum_n    = sum_q;
		xlo_n    = xlo_q;
		res_n    = '0;
		unique case (phase_q)
			PH_FIRST: begin
				leader_n = tape_byte;
				phase_n  = (tape_byte == 8'd0) ? PH_SCAN : PH_LEADER;
			end
			PH_LEADER: begin
				// first byte unlike the leader ends it; then skip L loader bytes
				if (tape_byte != leader_q) begin
					remain_n = leader_q;
					phase_n  = (leader_q != 8'd0) ? PH_SKIP : PH_SCAN;
				end
			end
			PH_SKIP: begin
				remain_n = remain_dec;
				if (remain_dec == 8'd0) begin
					phase_n = PH_SCAN;
				end
			end
			PH_LEN: begin
				remain_n = tape_byte;
				phase_n  = PH_ALO;
			end
			PH_ALO: begin
				addr_n  = {8'd0, tape_byte};
				sum_n   = tape_byte;
				phase_n = PH_AHI;
			end
			PH_AHI: begin
				addr_n  = {tape_byte, addr_q[7:0]};
				sum_n   = sum_q + tape_byte;
				// empty record: next byte is already the checksum
				phase_n = (remain_q != 8'd0) ? PH_DATA : PH_CSUM;
			end
			PH_DATA: begin
				res_n.write_valid   = 1'b1;
				res_n.write_address = addr_q;
				res_n.write_data    = tape_byte;
				addr_n   = addr_q + 16'd1;      // wraps at the top of memory
				sum_n    = sum_q + tape_byte;
				remain_n = remain_dec;
				if (remain_dec == 8'd0) begin
					phase_n = PH_CSUM;
				end
			end
			PH_CSUM: begin
				// mismatch is flagged only; loading carries on
				res_n.record_end     = 1'b1;
				res_n.checksum_error = (sum_q != tape_byte);
				phase_n = PH_SCAN;
			end
			PH_XLO: begin
				xlo_n   = tape_byte;
				phase_n = PH_XHI;
			end
			PH_XHI: begin
				res_n.exec_valid   = 1'b1;
				res_n.exec_address = {tape_byte, xlo_q};
				res_n.finished     = 1'b1;
				phase_n = PH_DONE;
			end
			PH_DONE: begin
				res_n.finished = 1'b1;
			end
			default: begin
				// between records: look for a record mark
				if (tape_byte == DATA_MARK) begin
					phase_n = PH_LEN;
				end else if (tape_byte == EXEC_MARK) begin
					phase_n = PH_XLO;
				end else begin
					phase_n = PH_SCAN;
				end
			end
		endcase
	end

	// Parse state advances once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			leader_q <= '0;
			remain_q <= '0;
			addr_q   <= '0;
			sum_q    <= '0;
			xlo_q    <= '0;
		end else if (in_fire) begin
			phase_q  <= phase_n;
			leader_q <= leader_n;
			remain_q <= remain_n;
			addr_q   <= addr_n;
			sum_q    <= sum_n;
			xlo_q    <= xlo_n;
		end
	end

	// Output stage: result register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (res_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				res_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				res_q <= skid_q;
			end
		end else if (in_fire) begin
			if (res_valid_q && !out_fire) begin
				skid_q <= res_n;
			end else begin
				res_q <= res_n;
			end
		end
	end

	assign result_valid   = res_valid_q;
	assign write_valid    = res_q.write_valid;
	assign write_address  = res_q.write_address;
	assign write_data     = res_q.write_data;
	assign record_end     = res_q.record_end;
	assign checksum_error = res_q.checksum_error;
	assign exec_valid     = res_q.exec_valid;
	assign exec_address   = res_q.exec_address;
	assign finished       = res_q.finished;

	// skid entry only fills behind a full result register
	`ASSERT_ALWAYS(a_skid_behind_res, !arst_n || !skid_valid_q || res_valid_q, "lone skid")
	// checksum error only ever rides with a record end
	`ASSERT_CLK(a_csum_with_end, (result_valid && checksum_error) |-> record_end, "stray error")
	// a word is either a memory write or the execute address, never both
	`ASSERT_CLK(a_write_xor_exec, result_valid |-> !(write_valid && exec_valid), "both set")
	// once the execute record is done the parser stays done
	`ASSERT_CLK(a_done_sticks, (phase_q == PH_DONE) |=> (phase_q == PH_DONE), "left done phase")

endmodule
